FILE: rtl/shpm_pkg.sv
// Package for the strafe heading PID mixer: sequencer states, request codes,
// register indexes and pulse constants. No dependencies.
package shpm_pkg;

  // request kinds carried in req_type
  localparam logic [1:0] REQ_RIGHT  = 2'd0;
  localparam logic [1:0] REQ_LEFT   = 2'd1;
  localparam logic [1:0] REQ_SAMPLE = 2'd2;
  localparam logic [1:0] REQ_UNDEF  = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_RIGHT_KP = 3'd0;
  localparam logic [2:0] CFG_RIGHT_KI = 3'd1;
  localparam logic [2:0] CFG_RIGHT_KD = 3'd2;
  localparam logic [2:0] CFG_LEFT_KP  = 3'd3;
  localparam logic [2:0] CFG_LEFT_KI  = 3'd4;
  localparam logic [2:0] CFG_LEFT_KD  = 3'd5;
  localparam logic [2:0] CFG_SPEED    = 3'd6;
  localparam logic [2:0] CFG_DEADBAND = 3'd7;

  // heading constants, Q3.13
  localparam logic signed [17:0] HALF_TURN = 18'sd25736;
  localparam logic signed [17:0] FULL_TURN = 18'sd51472;

  // pulse widths in us
  localparam logic signed [17:0] US_NEUTRAL = 18'sd1500;
  localparam logic signed [17:0] US_MIN     = 18'sd1250;
  localparam logic signed [17:0] US_MAX     = 18'sd1750;
  localparam logic [10:0]        US_IDLE    = 11'd1500;

  // divider constant and integral limits
  localparam logic [31:0] MILLI = 32'd1000;
  localparam logic signed [49:0] INT_MAX48 = 50'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [49:0] INT_MIN48 = -50'sh0_8000_0000_0000;
  localparam logic [71:0] TERM_LIMIT = 72'h1 << 60;

  // divide by 1000 in 16-bit digits: ceil(2^36 / 1000), exact for 26-bit values
  localparam logic [32:0] RECIP_MILLI = 33'd68719477;
  localparam logic [1:0]  KDIV_LAST   = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHECK, ST_MEI, ST_AEI, ST_DQ0, ST_DQM, ST_DQA, ST_MDL, ST_DR0,
    ST_DRW, ST_MP, ST_AP, ST_MGR, ST_DG0, ST_DGM, ST_DGA, ST_MQL, ST_AQL, ST_MQH,
    ST_AQH, ST_ACI, ST_MD, ST_AD, ST_ROT, ST_MIX, ST_OUT
  } state_t;

endpackage

FILE: rtl/shpm_req_if.sv
// Request channel: valid/ready plus one request item.
// Depends on nothing.
interface shpm_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [15:0] heading;
  logic [31:0]        now_ms;
  logic [31:0]        duration_ms;

  modport source (output valid, req_type, heading, now_ms, duration_ms, input ready);
  modport sink   (input valid, req_type, heading, now_ms, duration_ms, output ready);
endinterface

FILE: rtl/shpm_res_if.sv
// Result channel: valid/ready plus the four wheel pulses and status.
// Depends on nothing.
interface shpm_res_if;
  logic               valid;
  logic               ready;
  logic [10:0]        left_front_us;
  logic [10:0]        left_rear_us;
  logic [10:0]        right_rear_us;
  logic [10:0]        right_front_us;
  logic signed [15:0] rotation_cmd;
  logic               strafing;

  modport source (output valid, left_front_us, left_rear_us, right_rear_us,
                  right_front_us, rotation_cmd, strafing, input ready);
  modport sink   (input valid, left_front_us, left_rear_us, right_rear_us,
                  right_front_us, rotation_cmd, strafing, output ready);
endinterface

FILE: rtl/strafe_heading_pid_mixer_core.sv
// Strafe heading-hold PID with mecanum mixing: sequencer, shared multiplier,
// state and mixer. Depends on shpm_pkg, shpm_req_if, shpm_res_if, shpm_div.
//
//  channel | dir | handshake   | payload
//  req     | in  | valid/ready | req_type, heading, now_ms, duration_ms
//  res     | out | valid/ready | four wheel pulses, rotation_cmd, strafing
//  cfg     | in  | cfg_wr_en   | cfg_index, cfg_data
//
// Start items and unknown kinds are taken in idle and give no result transfer.
// A running sample passes the 48-step divide of the rate term, two divides by
// 1000 (three reciprocal multiplies each) and the other seven multiplies before
// its result is offered. Idle or expired samples go from the check straight to
// the result; zero-step ones pass through the mixer first. req.ready is low
// from acceptance until the result transfers; a stalled result holds. Reset
// is synchronous and clears sequencer, config and strafe state, not datapath.
module strafe_heading_pid_mixer_core
  import shpm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  shpm_req_if.sink    req,
  shpm_res_if.source  res,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  state_t state, state_next;

  // configuration
  logic signed [31:0] kp [2];
  logic signed [31:0] ki [2];
  logic signed [31:0] kd [2];
  logic [8:0]         strafe_speed;
  logic [7:0]         dead_band;

  // strafe state
  logic signed [15:0] target_heading;
  logic               going_left;
  logic               active;
  logic [31:0]        strafe_start;
  logic [31:0]        strafe_length;
  logic signed [47:0] error_integral [2];
  logic signed [15:0] previous_error [2];
  logic [31:0]        last_sample_time [2];

  // captured sample
  logic signed [15:0] cur;
  logic [31:0]        now_r;

  // working registers
  logic signed [15:0] err;
  logic signed [16:0] delta;
  logic [31:0]        span;
  logic signed [65:0] prod;
  logic signed [63:0] accum;
  logic [71:0]        mag;
  logic [47:0]        qmag;
  logic               dsign;
  logic               isign;
  logic signed [10:0] rem_s;
  logic signed [26:0] rate;
  logic signed [15:0] rot;

  // divide by 1000, one 16-bit digit per pass
  logic [47:0]        kdiv_num;
  logic [47:0]        kdiv_q;
  logic [9:0]         kdiv_r;
  logic [1:0]         kcnt;
  logic [25:0]        kv, krem;
  logic [15:0]        kq;
  logic [47:0]        kq_full;

  // divider
  logic        div_start, div_done;
  logic [47:0] div_num, div_quo;
  logic [31:0] div_den, div_rem;

  // shared multiplier operands
  logic signed [32:0] mul_a, mul_b;

  logic               d;
  logic [31:0]        elapsed, span_c;
  logic signed [17:0] diff;
  logic signed [31:0] gi;
  logic [31:0]        gi_mag;
  logic [65:0]        prod_mag;
  logic [47:0]        int_mag;
  logic signed [49:0] int_sum;
  logic signed [47:0] int_sat;
  logic [71:0]        mag_lim;
  logic signed [63:0] accum_adj, rot_wide;
  logic signed [9:0]  side;
  logic signed [17:0] raw_plus, raw_minus;

  function automatic logic [10:0] wheel_limit(logic signed [17:0] v, logic [7:0] db);
    logic signed [17:0] c, lo, hi;
    c  = v;
    lo = US_NEUTRAL - $signed({10'd0, db});
    hi = US_NEUTRAL + $signed({10'd0, db});
    if (c < US_MIN) c = US_MIN;
    if (c > US_MAX) c = US_MAX;
    if (c > lo && c < US_NEUTRAL) c = lo;
    if (c < hi && c > US_NEUTRAL) c = hi;
    return c[10:0];
  endfunction

  assign d = going_left;
  assign gi = ki[d];
  assign gi_mag = gi[31] ? 32'(-gi) : 32'(gi);
  assign prod_mag = prod[65] ? 66'(-prod) : 66'(prod);
  assign int_mag = error_integral[d][47] ? 48'(-error_integral[d])
                                         : 48'(error_integral[d]);
  assign elapsed = now_r - strafe_start;
  assign span_c  = now_r - last_sample_time[d];
  assign diff    = 18'(target_heading) - 18'(cur);

  // digit step: remainder and next 16 bits over 1000 via reciprocal product
  assign kv      = {kdiv_r, kdiv_num[47:32]};
  assign kq      = prod[51:36];
  assign krem    = kv - ({10'd0, kq} * 26'(MILLI));
  assign kq_full = {kdiv_q[31:0], kq};

  // integral update with 48-bit saturation
  assign int_sum = 50'(error_integral[d]) + prod[49:0];
  always_comb begin
    if (int_sum > INT_MAX48)      int_sat = INT_MAX48[47:0];
    else if (int_sum < INT_MIN48) int_sat = INT_MIN48[47:0];
    else                          int_sat = int_sum[47:0];
  end

  assign mag_lim   = (mag > TERM_LIMIT) ? TERM_LIMIT : mag;
  assign accum_adj = accum + (accum[63] ? 64'sd536870911 : 64'sd0);
  assign rot_wide  = accum_adj >>> 29;

  assign side      = going_left ? -$signed({1'b0, strafe_speed})
                                :  $signed({1'b0, strafe_speed});
  assign raw_plus  = US_NEUTRAL + 18'(side) - 18'(rot);
  assign raw_minus = US_NEUTRAL - 18'(side) - 18'(rot);

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_MEI: begin mul_a = 33'(err);          mul_b = {1'b0, span}; end
      ST_DQM, ST_DGM: begin mul_a = {7'd0, kv}; mul_b = RECIP_MILLI; end
      ST_MDL: begin mul_a = 33'(delta);        mul_b = {1'b0, MILLI}; end
      ST_MP:  begin mul_a = 33'(kp[d]);        mul_b = 33'(err); end
      ST_MGR: begin mul_a = 33'(gi);           mul_b = 33'(rem_s); end
      ST_MQL: begin mul_a = {1'b0, gi_mag};    mul_b = {1'b0, qmag[31:0]}; end
      ST_MQH: begin mul_a = {1'b0, gi_mag};    mul_b = {17'd0, qmag[47:32]}; end
      ST_MD:  begin mul_a = 33'(kd[d]);        mul_b = 33'(rate); end
      default: begin mul_a = '0;               mul_b = '0; end
    endcase
  end

  // divider operand select
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = MILLI;
    unique case (state)
      ST_DR0: begin div_start = 1'b1; div_num = prod_mag[47:0]; div_den = span; end
      default: div_start = 1'b0;
    endcase
  end

  shpm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (req.valid && req.req_type == REQ_SAMPLE) state_next = ST_CHECK;
      ST_CHECK: begin
        if (!active || elapsed >= strafe_length) state_next = ST_OUT;
        else if (span_c == 32'd0)               state_next = ST_MIX;
        else                                    state_next = ST_MEI;
      end
      ST_MEI:  state_next = ST_AEI;
      ST_AEI:  state_next = ST_DQ0;
      ST_DQ0:  state_next = ST_DQM;
      ST_DQM:  state_next = ST_DQA;
      ST_DQA:  state_next = (kcnt == KDIV_LAST) ? ST_MDL : ST_DQM;
      ST_MDL:  state_next = ST_DR0;
      ST_DR0:  state_next = ST_DRW;
      ST_DRW:  if (div_done) state_next = ST_MP;
      ST_MP:   state_next = ST_AP;
      ST_AP:   state_next = ST_MGR;
      ST_MGR:  state_next = ST_DG0;
      ST_DG0:  state_next = ST_DGM;
      ST_DGM:  state_next = ST_DGA;
      ST_DGA:  state_next = (kcnt == KDIV_LAST) ? ST_MQL : ST_DGM;
      ST_MQL:  state_next = ST_AQL;
      ST_AQL:  state_next = ST_MQH;
      ST_MQH:  state_next = ST_AQH;
      ST_AQH:  state_next = ST_ACI;
      ST_ACI:  state_next = ST_MD;
      ST_MD:   state_next = ST_AD;
      ST_AD:   state_next = ST_ROT;
      ST_ROT:  state_next = ST_MIX;
      ST_MIX:  state_next = ST_OUT;
      ST_OUT:  if (res.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    req.ready = (state == ST_IDLE);
    res.valid = (state == ST_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      kp[0] <= 32'sd17039360; ki[0] <= 32'sd328;     kd[0] <= 32'sd0;
      kp[1] <= 32'sd32768000; ki[1] <= 32'sd6553600; kd[1] <= 32'sd6553600;
      strafe_speed <= 9'd250;
      dead_band    <= 8'd150;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_RIGHT_KP: kp[0] <= cfg_data;
        CFG_RIGHT_KI: ki[0] <= cfg_data;
        CFG_RIGHT_KD: kd[0] <= cfg_data;
        CFG_LEFT_KP:  kp[1] <= cfg_data;
        CFG_LEFT_KI:  ki[1] <= cfg_data;
        CFG_LEFT_KD:  kd[1] <= cfg_data;
        CFG_SPEED:    strafe_speed <= cfg_data[8:0];
        CFG_DEADBAND: dead_band <= cfg_data[7:0];
      endcase
    end
  end

  // strafe and per-direction PID state
  always_ff @(posedge clk) begin
    if (rst) begin
      target_heading <= '0;
      going_left     <= 1'b0;
      active         <= 1'b0;
      strafe_start   <= '0;
      strafe_length  <= '0;
      for (int i = 0; i < 2; i++) begin
        error_integral[i]   <= '0;
        previous_error[i]   <= '0;
        last_sample_time[i] <= '0;
      end
    end else begin
      if (state == ST_IDLE && req.valid &&
          (req.req_type == REQ_RIGHT || req.req_type == REQ_LEFT)) begin
        target_heading <= req.heading;
        going_left     <= (req.req_type == REQ_LEFT);
        active         <= 1'b1;
        strafe_start   <= req.now_ms;
        strafe_length  <= req.duration_ms;
      end
      if (state == ST_CHECK && (!active || elapsed >= strafe_length)) active <= 1'b0;
      if (state == ST_AEI) error_integral[d] <= int_sat;
      if (state == ST_ROT) begin
        previous_error[d]   <= err;
        last_sample_time[d] <= now_r;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        cur   <= req.heading;
        now_r <= req.now_ms;
      end
      ST_CHECK: begin
        span <= span_c;
        rot  <= '0;
        // wrap error into one half turn either side
        if (diff > HALF_TURN)       err <= 16'(diff - FULL_TURN);
        else if (diff < -HALF_TURN) err <= 16'(diff + FULL_TURN);
        else                        err <= diff[15:0];
        res.left_front_us  <= US_IDLE;
        res.left_rear_us   <= US_IDLE;
        res.right_rear_us  <= US_IDLE;
        res.right_front_us <= US_IDLE;
        res.rotation_cmd   <= '0;
        res.strafing       <= 1'b0;
      end
      ST_MEI: begin
        prod  <= mul_a * mul_b;
        delta <= 17'(err) - 17'(previous_error[d]);
      end
      // integral magnitude over 1000
      ST_DQ0: begin
        isign    <= error_integral[d][47];
        kdiv_num <= int_mag;
        kdiv_q   <= '0;
        kdiv_r   <= '0;
        kcnt     <= '0;
      end
      ST_DQA: begin
        kdiv_num <= {kdiv_num[31:0], 16'd0};
        kdiv_q   <= kq_full;
        kdiv_r   <= krem[9:0];
        kcnt     <= kcnt + 2'd1;
        if (kcnt == KDIV_LAST) begin
          qmag  <= kq_full;
          rem_s <= isign ? -$signed({1'b0, krem[9:0]}) : $signed({1'b0, krem[9:0]});
        end
      end
      ST_DR0: dsign <= prod[65];
      ST_DRW: if (div_done) begin
        rate <= dsign ? -$signed(div_quo[26:0]) : $signed(div_quo[26:0]);
      end
      ST_AP:  accum <= prod[63:0];
      // gain times remainder over 1000
      ST_DG0: begin
        dsign    <= prod[65];
        kdiv_num <= prod_mag[47:0];
        kdiv_q   <= '0;
        kdiv_r   <= '0;
        kcnt     <= '0;
      end
      ST_DGA: begin
        kdiv_num <= {kdiv_num[31:0], 16'd0};
        kdiv_q   <= kq_full;
        kdiv_r   <= krem[9:0];
        kcnt     <= kcnt + 2'd1;
        if (kcnt == KDIV_LAST) begin
          accum <= dsign ? accum - $signed({16'd0, kq_full})
                         : accum + $signed({16'd0, kq_full});
        end
      end
      ST_AQL: mag <= {8'd0, prod[63:0]};
      ST_AQH: mag <= mag + {prod[39:0], 32'd0};
      ST_ACI: begin
        accum <= (gi[31] ^ isign) ? accum - $signed(mag_lim[63:0])
                                  : accum + $signed(mag_lim[63:0]);
      end
      ST_AD:  accum <= accum + prod[63:0];
      ST_ROT: begin
        if (rot_wide > 64'sd32767)       rot <= 16'sh7FFF;
        else if (rot_wide < -64'sd32768) rot <= -16'sh8000;
        else                             rot <= rot_wide[15:0];
      end
      ST_MIX: begin
        res.left_front_us  <= wheel_limit(raw_plus, dead_band);
        res.right_front_us <= wheel_limit(raw_plus, dead_band);
        res.left_rear_us   <= wheel_limit(raw_minus, dead_band);
        res.right_rear_us  <= wheel_limit(raw_minus, dead_band);
        res.rotation_cmd   <= rot;
        res.strafing       <= 1'b1;
      end
      ST_MDL, ST_MP, ST_MGR, ST_MQL, ST_MQH, ST_MD, ST_DQM, ST_DGM:
        prod <= mul_a * mul_b;
      default: ;
    endcase
  end

endmodule

FILE: rtl/shpm_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// 48-bit dividend, 32-bit divisor. Depends on nothing.
module shpm_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [47:0] quo,
  output logic [31:0] rem
);
  localparam int unsigned STEPS = 48;
  localparam int unsigned CW    = $clog2(STEPS + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [31:0]   den_r;
  logic [32:0]   trial;
  logic          fits;

  // shift in next dividend bit and test against divisor
  assign trial = {rem, quo[47]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(STEPS);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      if (fits) begin
        rem <= 32'(trial - {1'b0, den_r});
        quo <= {quo[46:0], 1'b1};
      end else begin
        rem <= trial[31:0];
        quo <= {quo[46:0], 1'b0};
      end
    end
  end
endmodule

FILE: rtl/shpm_checker.sv
// Port-level checks for the strafe heading PID mixer, bound to the top level.
// Depends on shpm_pkg.
module shpm_checker
  import shpm_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               res_valid,
  input logic               res_ready,
  input logic [10:0]        left_front_us,
  input logic [10:0]        left_rear_us,
  input logic [10:0]        right_rear_us,
  input logic [10:0]        right_front_us,
  input logic signed [15:0] rotation_cmd,
  input logic               strafing
);

  // one item in flight: never ready while a result is offered
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    !(req_ready && res_valid))
    else $error("input ready while result pending");

  // neutral results are fully neutral
  a_neutral: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !strafing) |-> (left_front_us == US_IDLE &&
      left_rear_us == US_IDLE && right_rear_us == US_IDLE &&
      right_front_us == US_IDLE && rotation_cmd == 16'sd0))
    else $error("neutral result not neutral");

  // mecanum diagonals match
  a_diag: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (left_front_us == right_front_us && left_rear_us == right_rear_us))
    else $error("diagonal wheel pulses differ");

  // pulses stay within clamp plus worst deadband push
  a_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (left_front_us >= 11'd1245 && left_front_us <= 11'd1755 &&
                   left_rear_us >= 11'd1245 && left_rear_us <= 11'd1755))
    else $error("wheel pulse out of range");

  // a stalled result stays offered with rotation_cmd unchanged
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(rotation_cmd)))
    else $error("stalled result changed");

endmodule

bind strafe_heading_pid_mixer_core shpm_checker u_shpm_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .left_front_us  (res.left_front_us),
  .left_rear_us   (res.left_rear_us),
  .right_rear_us  (res.right_rear_us),
  .right_front_us (res.right_front_us),
  .rotation_cmd   (res.rotation_cmd),
  .strafing       (res.strafing)
);

FILE: bench/strafe_heading_pid_mixer_core_tb.sv
// Testbench for strafe_heading_pid_mixer_core: directed and random requests, checked
// against an in-bench PID/mixer predictor. Depends on shpm_pkg, shpm_req_if, shpm_res_if
// and the core RTL.
module strafe_heading_pid_mixer_core_tb;
  import shpm_pkg::*;

  localparam int NEUTRAL = 1500;
  localparam int PULSE_MIN = 1250;
  localparam int PULSE_MAX = 1750;
  localparam int HALF_Q13 = 25736;
  localparam int FULL_Q13 = 51472;
  localparam longint SUM_LIMIT = 64'sd1 << 60;
  localparam longint INTEG_MAX = 64'sh7FFF_FFFF_FFFF;
  localparam longint INTEG_MIN = -64'sh8000_0000_0000;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 200;

  typedef struct packed {
    logic [10:0]        lf;
    logic [10:0]        lr;
    logic [10:0]        rr;
    logic [10:0]        rf;
    logic signed [15:0] rot;
    logic               strafing;
  } wheel_cmd_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  shpm_req_if req_ch ();
  shpm_res_if res_ch ();

  strafe_heading_pid_mixer_core dut (
    .clk(clk), .rst(rst), .req(req_ch), .res(res_ch),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor copy of gains and state
  int           kp [2];
  int           ki [2];
  int           kd [2];
  int           speed_us;
  int           band_us;
  int           tgt_heading;
  bit           left_dir;
  bit           running;
  bit [31:0]    run_start;
  bit [31:0]    run_len;
  longint       integ [2];
  int           prev_err [2];
  bit [31:0]    last_t [2];

  wheel_cmd_t   pending_cmds [$];
  int           fail_count = 0;
  int           snd_idle_pct = 0;
  int           rcv_idle_pct = 0;
  int           quiet_cycles = 0;
  bit [31:0]    clock_ms;

  // saturating magnitude product, limit 2^60
  function automatic longint sat_product(longint a, longint b);
    bit [63:0] ua, ub, mag;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    if (ua != 0 && ub > SUM_LIMIT / ua) mag = SUM_LIMIT;
    else mag = ua * ub;
    if (mag > SUM_LIMIT) mag = SUM_LIMIT;
    return ((a < 0) != (b < 0)) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic int pid_rotation(int d, int cur, bit [31:0] t_now);
    bit [31:0] span;
    int        err, delta;
    longint    acc, rate, q, r, sum, rot;
    span = t_now - last_t[d];
    if (span == 0) return 0;
    err = tgt_heading - cur;
    while (err > HALF_Q13) err -= FULL_Q13;
    while (err < -HALF_Q13) err += FULL_Q13;
    acc = integ[d] + longint'(err) * longint'({32'd0, span});
    if (acc > INTEG_MAX) acc = INTEG_MAX;
    if (acc < INTEG_MIN) acc = INTEG_MIN;
    integ[d] = acc;
    delta = err - prev_err[d];
    rate = (longint'(delta) * 1000) / longint'({32'd0, span});
    q = acc / 1000;
    r = acc % 1000;
    sum = longint'(kp[d]) * err + sat_product(ki[d], q) + (longint'(ki[d]) * r) / 1000
        + longint'(kd[d]) * rate;
    prev_err[d] = err;
    last_t[d] = t_now;
    rot = sum / (64'sd1 << 29);
    if (rot > 32767) rot = 32767;
    if (rot < -32768) rot = -32768;
    return int'(rot);
  endfunction

  function automatic logic [10:0] limit_pulse(int v);
    if (v < PULSE_MIN) v = PULSE_MIN;
    if (v > PULSE_MAX) v = PULSE_MAX;
    if (v > NEUTRAL - band_us && v < NEUTRAL) v = NEUTRAL - band_us;
    if (v < NEUTRAL + band_us && v > NEUTRAL) v = NEUTRAL + band_us;
    return v[10:0];
  endfunction

  // one accepted request: update state, queue the expected wheel command
  function automatic void predict_request(logic [1:0] kind, logic signed [15:0] hdg,
                                          bit [31:0] t_now, bit [31:0] len);
    wheel_cmd_t c;
    int         rot, side;
    if (kind == REQ_RIGHT || kind == REQ_LEFT) begin
      tgt_heading = hdg;
      left_dir = (kind == REQ_LEFT);
      running = 1'b1;
      run_start = t_now;
      run_len = len;
      return;
    end
    if (kind != REQ_SAMPLE) return;
    if (!running || (t_now - run_start) >= run_len) begin
      running = 1'b0;
      c = '{11'd1500, 11'd1500, 11'd1500, 11'd1500, 16'sd0, 1'b0};
    end else begin
      rot = pid_rotation(left_dir, hdg, t_now);
      side = left_dir ? -speed_us : speed_us;
      c.lf = limit_pulse(NEUTRAL + side - rot);
      c.lr = limit_pulse(NEUTRAL - side - rot);
      c.rr = limit_pulse(NEUTRAL - side - rot);
      c.rf = limit_pulse(NEUTRAL + side - rot);
      c.rot = rot[15:0];
      c.strafing = 1'b1;
    end
    pending_cmds.push_back(c);
  endfunction

  task automatic model_reset();
    kp = '{17039360, 32768000};
    ki = '{328, 6553600};
    kd = '{0, 6553600};
    speed_us = 250;
    band_us = 150;
    tgt_heading = 0;
    left_dir = 0;
    running = 0;
    run_start = 0;
    run_len = 0;
    integ = '{0, 0};
    prev_err = '{0, 0};
    last_t = '{0, 0};
  endtask

  // register write, only while the core is idle
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    case (idx)
      CFG_RIGHT_KP: kp[0] = val;
      CFG_RIGHT_KI: ki[0] = val;
      CFG_RIGHT_KD: kd[0] = val;
      CFG_LEFT_KP:  kp[1] = val;
      CFG_LEFT_KI:  ki[1] = val;
      CFG_LEFT_KD:  kd[1] = val;
      CFG_SPEED:    speed_us = int'(val[8:0]);
      CFG_DEADBAND: band_us = int'(val[7:0]);
      default: ;
    endcase
  endtask

  // stop sending, then wait for every expected result and some quiet cycles
  task automatic wait_drained();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (pending_cmds.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_all(logic [31:0] g0, logic [31:0] g1, logic [31:0] g2,
                           logic [31:0] g3, logic [31:0] g4, logic [31:0] g5,
                           logic [31:0] spd, logic [31:0] band);
    wait_drained();
    write_reg(CFG_RIGHT_KP, g0);
    write_reg(CFG_RIGHT_KI, g1);
    write_reg(CFG_RIGHT_KD, g2);
    write_reg(CFG_LEFT_KP, g3);
    write_reg(CFG_LEFT_KI, g4);
    write_reg(CFG_LEFT_KD, g5);
    write_reg(CFG_SPEED, spd);
    write_reg(CFG_DEADBAND, band);
  endtask

  // drive one request and wait for its transfer
  task automatic send_request(logic [1:0] kind, logic signed [15:0] hdg,
                              logic [31:0] t_now, logic [31:0] len);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.req_type = kind;
    req_ch.heading = hdg;
    req_ch.now_ms = t_now;
    req_ch.duration_ms = len;
    do @(posedge clk); while (!req_ch.ready);
    predict_request(kind, hdg, t_now, len);
  endtask

  // receiver stalls
  always @(negedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // result checker
  always @(posedge clk) begin
    wheel_cmd_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_cmds.size() == 0) begin
        $error("unexpected result transfer");
        fail_count++;
      end else begin
        want = pending_cmds.pop_front();
        if (res_ch.left_front_us !== want.lf) begin
          $error("left_front_us exp %0d got %0d", want.lf, res_ch.left_front_us);
          fail_count++;
        end
        if (res_ch.left_rear_us !== want.lr) begin
          $error("left_rear_us exp %0d got %0d", want.lr, res_ch.left_rear_us);
          fail_count++;
        end
        if (res_ch.right_rear_us !== want.rr) begin
          $error("right_rear_us exp %0d got %0d", want.rr, res_ch.right_rear_us);
          fail_count++;
        end
        if (res_ch.right_front_us !== want.rf) begin
          $error("right_front_us exp %0d got %0d", want.rf, res_ch.right_front_us);
          fail_count++;
        end
        if (res_ch.rotation_cmd !== want.rot) begin
          $error("rotation_cmd exp %0d got %0d", want.rot, res_ch.rotation_cmd);
          fail_count++;
        end
        if (res_ch.strafing !== want.strafing) begin
          $error("strafing exp %0d got %0d", want.strafing, res_ch.strafing);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // directed: idle sample, dt of zero, wrap extremes, expiry, unknown kind
  task automatic test_directed();
    send_request(REQ_SAMPLE, 16'sd0, 32'd5, 32'd0);
    send_request(REQ_RIGHT, 16'sd32767, 32'd0, 32'd1000);
    send_request(REQ_SAMPLE, 16'sd32767, 32'd0, 32'd0);
    send_request(REQ_SAMPLE, -16'sd32768, 32'd20, 32'hFFFF_FFFF);
    send_request(REQ_SAMPLE, 16'sd0, 32'd40, 32'd0);
    send_request(REQ_SAMPLE, 16'sd32767, 32'd999, 32'd0);
    send_request(REQ_UNDEF, 16'sd100, 32'd1000, 32'd5);
    send_request(REQ_SAMPLE, 16'sd0, 32'd1000, 32'd0);
    send_request(REQ_SAMPLE, 16'sd0, 32'd1020, 32'd0);
    send_request(REQ_LEFT, -16'sd32768, 32'hFFFF_FFF0, 32'd100);
    send_request(REQ_SAMPLE, 16'sd32767, 32'hFFFF_FFFA, 32'd0);
    send_request(REQ_SAMPLE, -16'sd20000, 32'h0000_0010, 32'd0);
    send_request(REQ_SAMPLE, -16'sd20000, 32'h0000_0010, 32'd0);
    send_request(REQ_SAMPLE, 16'sd1, 32'h0000_0054, 32'd0);
    send_request(REQ_RIGHT, 16'sd0, 32'd7, 32'd0);
    send_request(REQ_SAMPLE, 16'sd0, 32'd7, 32'd0);
    send_request(REQ_LEFT, 16'sd5, 32'h8000_0000, 32'hFFFF_FFFF);
    send_request(REQ_SAMPLE, 16'sd5, 32'h0000_0000, 32'd0);
    send_request(REQ_SAMPLE, -16'sd5, 32'h7FFF_FFFF, 32'd0);
  endtask

  // extreme gains with the widest speed and deadband codes, then all-zero settings
  task automatic test_gain_extremes();
    write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd511, 32'd255);
    send_request(REQ_RIGHT, 16'sd1000, 32'd100, 32'd500);
    send_request(REQ_SAMPLE, -16'sd32768, 32'd120, 32'd0);
    send_request(REQ_SAMPLE, 16'sd32767, 32'd121, 32'd0);
    send_request(REQ_LEFT, -16'sd1000, 32'd200, 32'd500);
    send_request(REQ_SAMPLE, 16'sd32767, 32'd220, 32'd0);
    send_request(REQ_SAMPLE, -16'sd999, 32'd221, 32'd0);
    write_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_request(REQ_RIGHT, 16'sd0, 32'd300, 32'd50);
    send_request(REQ_SAMPLE, 16'sd4000, 32'd310, 32'd0);
  endtask

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'd0;
      3: return $urandom_range(0, 40000000);
      4: return -$urandom_range(0, 40000000);
      default: return $urandom;
    endcase
  endfunction

  // random strafes: mostly well-formed start/sample runs, some noise
  task automatic test_random_strafes(int n_items);
    int               sent;
    int               n_samples;
    logic signed [15:0] hdg0, hdg;
    logic [1:0]       kind;
    logic [31:0]      len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        kind = ($urandom_range(3) == 0) ? REQ_UNDEF : REQ_SAMPLE;
        send_request(kind, 16'($urandom), $urandom, $urandom);
        if (kind == REQ_SAMPLE) sent++;
        continue;
      end
      hdg0 = 16'($urandom);
      clock_ms = ($urandom_range(4) == 0) ? $urandom : clock_ms + $urandom_range(0, 100);
      len = ($urandom_range(7) == 0) ? $urandom : $urandom_range(0, 600);
      send_request(2'($urandom_range(1)), hdg0, clock_ms, len);
      sent++;
      n_samples = $urandom_range(1, 12);
      repeat (n_samples) begin
        clock_ms += ($urandom_range(9) == 0) ? $urandom_range(0, 2000)
                                               : $urandom_range(0, 40);
        hdg = ($urandom_range(5) == 0) ? 16'($urandom)
                                        : hdg0 + 16'($signed($urandom_range(0, 4000)) - 2000);
        send_request(REQ_SAMPLE, hdg, clock_ms, $urandom);
        sent++;
      end
    end
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_SAMPLE;
    req_ch.heading = '0;
    req_ch.now_ms = '0;
    req_ch.duration_ms = '0;
    res_ch.ready = 1'b0;
    model_reset();
    clock_ms = $urandom;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    snd_idle_pct = 9;
    rcv_idle_pct = 46;
    test_directed();
    test_gain_extremes();
    write_all(32'd17039360, 32'd328, 32'd0, 32'd32768000, 32'd6553600, 32'd6553600,
              32'd250, 32'd150);
    test_random_strafes(250);

    snd_idle_pct = 46;
    rcv_idle_pct = 9;
    write_all(pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_gain(),
              $urandom_range(0, 511), $urandom_range(0, 255));
    test_random_strafes(250);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    write_all(pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_gain(),
              32'd500, 32'd250);
    test_random_strafes(250);
    write_all(pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_gain(),
              $urandom_range(0, 511), $urandom_range(0, 255));
    test_random_strafes(250);

    @(negedge clk);
    req_ch.valid = 1'b0;
    wait_drained();
    if (fail_count == 0 && pending_cmds.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
